>>> src/kmma_pkg.sv
`default_nettype none

package kmma_pkg;

  localparam int STATIONS_DEF = 512;

  localparam int OP_W  = 2;
  localparam int IDX_W = 9;
  localparam int RD_W  = 11;
  localparam int SUM_W = 44;
  localparam int CNT_W = 32;

  localparam logic [OP_W-1:0] OP_RECORD = 2'd0;
  localparam logic [OP_W-1:0] OP_READ   = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  localparam logic signed [RD_W-1:0] EMPTY_MIN = 11'sd999;
  localparam logic signed [RD_W-1:0] EMPTY_MAX = -11'sd999;
  localparam logic [CNT_W-1:0] CNT_FULL = '1;

  localparam int DIV_STEPS = SUM_W;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic [CNT_W-1:0]        count;
    logic signed [RD_W-1:0]  lo;
    logic signed [RD_W-1:0]  hi;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

>>> src/keyed_min_mean_max_aggregator.sv
// channel   signals                                        dir
// request   in_valid in_ready opcode station_index          in
//           reading_tenths
// result    out_valid out_ready status present sample_count out
//           lowest_tenths highest_tenths average_tenths
//
// record, clear, empty read: table read, then write back
// read of a filled entry: table read, 44 divider steps, then the result
// after reset a clearing pass writes all STATIONS entries, one per cycle,
// with in_ready low throughout the pass
// a result waits in the output register while the next request is taken;
// that request holds at write-back or divide end till the register frees
`default_nettype none

module keyed_min_mean_max_aggregator #(
  parameter int STATIONS = kmma_pkg::STATIONS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic [kmma_pkg::OP_W-1:0]            opcode,
  input  wire logic [kmma_pkg::IDX_W-1:0]           station_index,
  input  wire logic signed [kmma_pkg::RD_W-1:0]     reading_tenths,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic                                      status,
  output logic                                      present,
  output logic [kmma_pkg::CNT_W-1:0]                sample_count,
  output logic signed [kmma_pkg::RD_W-1:0]          lowest_tenths,
  output logic signed [kmma_pkg::RD_W-1:0]          highest_tenths,
  output logic signed [kmma_pkg::RD_W-1:0]          average_tenths
);

  localparam int AW  = $clog2(STATIONS);
  localparam int XW  = (AW > kmma_pkg::IDX_W) ? AW : kmma_pkg::IDX_W;
  localparam int DCW = $clog2(kmma_pkg::DIV_STEPS + 1);

  typedef enum logic [3:0] {
    S_CLR  = 4'b0001,
    S_IDLE = 4'b0010,
    S_EXEC = 4'b0100,
    S_DIV  = 4'b1000
  } state_t;

  state_t state;

  logic [AW-1:0]                     clr_addr;
  logic [kmma_pkg::OP_W-1:0]         op_q;
  logic [AW-1:0]                     addr_q;
  logic                              valid_q;
  logic signed [kmma_pkg::RD_W-1:0]  reading_q;

  logic [kmma_pkg::SUM_W-1:0]        dvd;
  logic [kmma_pkg::CNT_W-1:0]        rem;
  logic [kmma_pkg::CNT_W-1:0]        dsr;
  logic                              div_neg;
  logic [DCW-1:0]                    div_cnt;

  logic                              rd_en;
  logic [AW-1:0]                     rd_addr;
  logic [kmma_pkg::ENTRY_W-1:0]      rd_data;
  logic                              wr_en;
  logic [AW-1:0]                     wr_addr;
  logic [kmma_pkg::ENTRY_W-1:0]      wr_data;

  logic [XW-1:0]                     idx_ext;
  logic                              in_valid_idx;
  logic                              accept;
  logic                              slot_free;
  kmma_pkg::entry_t                  cur;
  kmma_pkg::entry_t                  rec_entry;
  kmma_pkg::entry_t                  empty_entry;
  logic                              cnt_zero;
  logic                              cnt_full;
  logic                              start_div;
  logic                              exec_fire;
  logic                              div_done;
  logic                              load_out;
  logic [kmma_pkg::SUM_W-1:0]        mag;
  logic [kmma_pkg::SUM_W-1:0]        dvd_init;
  logic [kmma_pkg::CNT_W:0]          rem_sh;
  logic [kmma_pkg::CNT_W:0]          rem_diff;
  logic                              rem_ge;
  logic [kmma_pkg::RD_W-1:0]         q11;

  assign in_ready     = (state == S_IDLE);
  assign accept       = in_valid && in_ready;
  assign slot_free    = !out_valid || out_ready;
  assign idx_ext      = XW'(station_index);
  assign in_valid_idx = ({1'b0, idx_ext} < (XW + 1)'(STATIONS));

  assign cur      = kmma_pkg::entry_t'(rd_data);
  assign cnt_zero = (cur.count == '0);
  assign cnt_full = (cur.count == kmma_pkg::CNT_FULL);

  always_comb begin
    empty_entry.sum   = '0;
    empty_entry.count = '0;
    empty_entry.lo    = kmma_pkg::EMPTY_MIN;
    empty_entry.hi    = kmma_pkg::EMPTY_MAX;

    rec_entry.sum   = cur.sum + kmma_pkg::SUM_W'(reading_q);
    rec_entry.count = cur.count + 1'b1;
    rec_entry.lo    = (cnt_zero || reading_q < cur.lo) ? reading_q : cur.lo;
    rec_entry.hi    = (cnt_zero || reading_q > cur.hi) ? reading_q : cur.hi;
  end

  assign start_div = (state == S_EXEC) && (op_q == kmma_pkg::OP_READ) && valid_q && !cnt_zero;
  assign exec_fire = (state == S_EXEC) && !start_div && slot_free;

  assign mag      = cur.sum[kmma_pkg::SUM_W-1] ? (kmma_pkg::SUM_W'(0) - cur.sum) : cur.sum;
  assign dvd_init = mag + kmma_pkg::SUM_W'(cur.count >> 1);

  assign rem_sh   = {rem, dvd[kmma_pkg::SUM_W-1]};
  assign rem_diff = rem_sh - {1'b0, dsr};
  assign rem_ge   = (rem_sh >= {1'b0, dsr});
  assign div_done = (div_cnt == DCW'(kmma_pkg::DIV_STEPS));
  assign q11      = dvd[kmma_pkg::RD_W-1:0];
  assign load_out = exec_fire || ((state == S_DIV) && div_done && slot_free);

  always_comb begin
    rd_en   = accept;
    rd_addr = idx_ext[AW-1:0];
    wr_en   = 1'b0;
    wr_addr = addr_q;
    wr_data = rec_entry;
    case (state)
      S_CLR: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr;
        wr_data = empty_entry;
      end
      S_EXEC: begin
        if (exec_fire && valid_q) begin
          case (op_q)
            kmma_pkg::OP_RECORD: begin
              wr_en   = !cnt_full;
              wr_data = rec_entry;
            end
            kmma_pkg::OP_CLEAR: begin
              wr_en   = 1'b1;
              wr_data = empty_entry;
            end
            default: begin
              wr_en = 1'b0;
            end
          endcase
        end
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  kmma_ram #(
    .WIDTH(kmma_pkg::ENTRY_W),
    .DEPTH(STATIONS)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
      div_cnt   <= '0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(STATIONS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            op_q      <= opcode;
            addr_q    <= idx_ext[AW-1:0];
            valid_q   <= in_valid_idx;
            reading_q <= reading_tenths;
            state     <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (start_div) begin
            dvd     <= dvd_init;
            rem     <= '0;
            dsr     <= cur.count;
            div_neg <= cur.sum[kmma_pkg::SUM_W-1];
            div_cnt <= '0;
            state   <= S_DIV;
          end else if (exec_fire) begin
            status         <= (op_q == kmma_pkg::OP_RECORD) && valid_q && cnt_full;
            present        <= 1'b0;
            sample_count   <= '0;
            lowest_tenths  <= '0;
            highest_tenths <= '0;
            average_tenths <= '0;
            state          <= S_IDLE;
          end
        end
        S_DIV: begin
          if (!div_done) begin
            rem     <= rem_ge ? rem_diff[kmma_pkg::CNT_W-1:0] : rem_sh[kmma_pkg::CNT_W-1:0];
            dvd     <= {dvd[kmma_pkg::SUM_W-2:0], rem_ge};
            div_cnt <= div_cnt + 1'b1;
          end else if (slot_free) begin
            status         <= 1'b0;
            present        <= 1'b1;
            sample_count   <= cur.count;
            lowest_tenths  <= cur.lo;
            highest_tenths <= cur.hi;
            average_tenths <= div_neg ? (kmma_pkg::RD_W'(0) - q11) : q11;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_CLR;
        end
      endcase
    end
  end

  a_clr_no_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLR) |-> !out_valid)
    else $error("result during clearing pass");

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_EXEC))
    else $error("request not followed by write-back cycle");

  a_no_write_on_accept: assert property (@(posedge clk) disable iff (rst)
    accept |-> !wr_en)
    else $error("table write while a request is taken");

  a_present_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && present) |-> (sample_count != '0 && !status))
    else $error("present result with zero count or reject status");

  a_div_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (div_cnt <= DCW'(kmma_pkg::DIV_STEPS)))
    else $error("divider ran past its last step");

endmodule

`default_nettype wire

>>> src/kmma_ram.sv
`default_nettype none

module kmma_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> sim/kmma_stats_checker.sv
module kmma_stats_checker #(
  parameter int STATIONS = kmma_pkg::STATIONS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  input  wire logic                              in_ready,
  input  wire logic [kmma_pkg::OP_W-1:0]         opcode,
  input  wire logic [kmma_pkg::IDX_W-1:0]        station_index,
  input  wire logic signed [kmma_pkg::RD_W-1:0]  reading_tenths,
  input  wire logic                              out_valid,
  input  wire logic                              out_ready,
  input  wire logic                              status,
  input  wire logic                              present,
  input  wire logic [kmma_pkg::CNT_W-1:0]        sample_count,
  input  wire logic signed [kmma_pkg::RD_W-1:0]  lowest_tenths,
  input  wire logic signed [kmma_pkg::RD_W-1:0]  highest_tenths,
  input  wire logic signed [kmma_pkg::RD_W-1:0]  average_tenths,
  output int                                     errors,
  output int                                     outstanding
);

  typedef struct packed {
    logic [kmma_pkg::OP_W-1:0]        op;
    logic [kmma_pkg::IDX_W-1:0]       idx;
    logic                             status;
    logic                             present;
    logic [kmma_pkg::CNT_W-1:0]       count;
    logic signed [kmma_pkg::RD_W-1:0] lo;
    logic signed [kmma_pkg::RD_W-1:0] hi;
    logic signed [kmma_pkg::RD_W-1:0] avg;
  } station_summary_t;

  longint                           sum_tbl [STATIONS];
  logic [kmma_pkg::CNT_W-1:0]       tally_tbl [STATIONS];
  logic signed [kmma_pkg::RD_W-1:0] lo_tbl [STATIONS];
  logic signed [kmma_pkg::RD_W-1:0] hi_tbl [STATIONS];

  station_summary_t pending_summaries [$];
  int               result_seq;

  function automatic void empty_station(int i);
    sum_tbl[i]   = 0;
    tally_tbl[i] = '0;
    lo_tbl[i]    = kmma_pkg::EMPTY_MIN;
    hi_tbl[i]    = kmma_pkg::EMPTY_MAX;
  endfunction

  function automatic station_summary_t fold_request(logic [kmma_pkg::OP_W-1:0] op,
                                                    logic [kmma_pkg::IDX_W-1:0] idx,
                                                    logic signed [kmma_pkg::RD_W-1:0] rd);
    station_summary_t r;
    longint mag;
    longint cnt;
    longint q;
    r     = '0;
    r.op  = op;
    r.idx = idx;
    case (op)
      kmma_pkg::OP_RECORD: begin
        if (idx < STATIONS) begin
          if (tally_tbl[idx] == kmma_pkg::CNT_FULL) begin
            r.status = 1'b1;
          end else begin
            if (tally_tbl[idx] == '0) begin
              lo_tbl[idx] = rd;
              hi_tbl[idx] = rd;
            end else begin
              if (rd < lo_tbl[idx]) lo_tbl[idx] = rd;
              if (rd > hi_tbl[idx]) hi_tbl[idx] = rd;
            end
            sum_tbl[idx]   = sum_tbl[idx] + rd;
            tally_tbl[idx] = tally_tbl[idx] + 1'b1;
          end
        end
      end
      kmma_pkg::OP_READ: begin
        if (idx < STATIONS && tally_tbl[idx] != '0) begin
          cnt = tally_tbl[idx];
          mag = (sum_tbl[idx] < 0) ? -sum_tbl[idx] : sum_tbl[idx];
          // mean rounded half away from zero
          q = (mag + cnt / 2) / cnt;
          r.present = 1'b1;
          r.count   = tally_tbl[idx];
          r.lo      = lo_tbl[idx];
          r.hi      = hi_tbl[idx];
          r.avg     = kmma_pkg::RD_W'((sum_tbl[idx] < 0) ? -q : q);
        end
      end
      kmma_pkg::OP_CLEAR: begin
        if (idx < STATIONS) empty_station(idx);
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report(string what);
    errors++;
    $display("mismatch: %s", what);
  endtask

  task automatic check_field(string field, logic [31:0] got, logic [31:0] want,
                             station_summary_t s);
    if (got !== want)
      report($sformatf("result %0d (op %0d, station %0d) %s got %h want %h",
                       result_seq, s.op, s.idx, field, got, want));
  endtask

  always @(posedge clk) begin : watch
    station_summary_t want;
    if (rst) begin
      for (int i = 0; i < STATIONS; i++) empty_station(i);
      pending_summaries.delete();
      errors      = 0;
      outstanding = 0;
      result_seq  = 0;
    end else begin
      if (in_valid && in_ready)
        pending_summaries.push_back(fold_request(opcode, station_index, reading_tenths));
      if (out_valid && out_ready) begin
        if (pending_summaries.size() == 0) begin
          report($sformatf("result %0d arrived with no request waiting", result_seq));
        end else begin
          want = pending_summaries.pop_front();
          check_field("status", 32'(status), 32'(want.status), want);
          check_field("present", 32'(present), 32'(want.present), want);
          check_field("sample_count", sample_count, want.count, want);
          check_field("lowest_tenths", 32'(lowest_tenths), 32'(want.lo), want);
          check_field("highest_tenths", 32'(highest_tenths), 32'(want.hi), want);
          check_field("average_tenths", 32'(average_tenths), 32'(want.avg), want);
        end
        result_seq++;
      end
      outstanding = pending_summaries.size();
    end
  end

endmodule

>>> sim/keyed_min_mean_max_aggregator_tb.sv
module keyed_min_mean_max_aggregator_tb;

  localparam logic [kmma_pkg::OP_W-1:0] OP_NOP = 2'd3;
  localparam int ITEMS           = 1050;
  localparam int CALM_TAIL       = 120;
  localparam int PRESSURE_AT     = 400;
  localparam int PRESSURE_CYCLES = 200;
  localparam int QUIET_LIMIT     = 4000;
  localparam int DRAIN_CYCLES    = 64;

  logic                             clk;
  logic                             rst = 1'b1;
  logic                             in_valid = 1'b0;
  logic                             in_ready;
  logic [kmma_pkg::OP_W-1:0]        opcode = '0;
  logic [kmma_pkg::IDX_W-1:0]       station_index = '0;
  logic signed [kmma_pkg::RD_W-1:0] reading_tenths = '0;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  logic                             status;
  logic                             present;
  logic [kmma_pkg::CNT_W-1:0]       sample_count;
  logic signed [kmma_pkg::RD_W-1:0] lowest_tenths;
  logic signed [kmma_pkg::RD_W-1:0] highest_tenths;
  logic signed [kmma_pkg::RD_W-1:0] average_tenths;

  int   errors;
  int   outstanding;
  int   sent = 0;
  bit   calm = 1'b0;
  logic in_took = 1'b0;
  int   quiet = 0;

  logic [kmma_pkg::IDX_W-1:0] hot_keys [8];

  keyed_min_mean_max_aggregator DUT (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .opcode         (opcode),
    .station_index  (station_index),
    .reading_tenths (reading_tenths),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .present        (present),
    .sample_count   (sample_count),
    .lowest_tenths  (lowest_tenths),
    .highest_tenths (highest_tenths),
    .average_tenths (average_tenths)
  );

  kmma_stats_checker stats_check (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .opcode         (opcode),
    .station_index  (station_index),
    .reading_tenths (reading_tenths),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .present        (present),
    .sample_count   (sample_count),
    .lowest_tenths  (lowest_tenths),
    .highest_tenths (highest_tenths),
    .average_tenths (average_tenths),
    .errors         (errors),
    .outstanding    (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    in_took <= in_valid && in_ready;
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  function automatic logic signed [kmma_pkg::RD_W-1:0] sample_reading();
    logic signed [kmma_pkg::RD_W-1:0] v;
    if ($urandom_range(0, 7) == 0) v = kmma_pkg::RD_W'($urandom_range(0, 2047));
    else v = kmma_pkg::RD_W'(int'($urandom_range(0, 1998)) - 999);
    return v;
  endfunction

  task automatic send_item(input logic [kmma_pkg::OP_W-1:0] op,
                           input logic [kmma_pkg::IDX_W-1:0] idx,
                           input logic signed [kmma_pkg::RD_W-1:0] rd);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid       <= 1'b1;
    opcode         <= op;
    station_index  <= idx;
    reading_tenths <= rd;
    @(negedge clk);
    while (!in_took) @(negedge clk);
    sent++;
    if (sent >= ITEMS - CALM_TAIL) calm = 1'b1;
  endtask

  // result side: random stalls plus one long hold-off to back up the request side
  initial begin : result_sink
    bit pressed;
    pressed = 1'b0;
    forever begin
      @(negedge clk);
      if (!pressed && sent >= PRESSURE_AT) begin
        pressed = 1'b1;
        out_ready <= 1'b0;
        repeat (PRESSURE_CYCLES) @(negedge clk);
        out_ready <= 1'b1;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(negedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : request_source
    logic [kmma_pkg::IDX_W-1:0] key;
    logic [kmma_pkg::OP_W-1:0]  op;
    int                         n;
    hot_keys[0] = '0;
    hot_keys[1] = '1;
    for (int i = 2; i < 8; i++) hot_keys[i] = kmma_pkg::IDX_W'($urandom_range(0, 511));
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    send_item(kmma_pkg::OP_READ, 9'd0, 11'sd0);
    send_item(OP_NOP, 9'd5, -11'sd1);
    // first sample outside the usual range replaces the empty min and max
    send_item(kmma_pkg::OP_RECORD, 9'd0, 11'sd1023);
    send_item(kmma_pkg::OP_READ, 9'd0, 11'sd0);
    send_item(kmma_pkg::OP_RECORD, 9'd0, 11'h400);
    send_item(kmma_pkg::OP_READ, 9'd0, 11'sd0);
    send_item(kmma_pkg::OP_RECORD, 9'd511, 11'sd999);
    send_item(kmma_pkg::OP_RECORD, 9'd511, -11'sd999);
    send_item(kmma_pkg::OP_RECORD, 9'd511, 11'sd0);
    send_item(kmma_pkg::OP_READ, 9'd511, 11'h7ff);
    // half-way means round away from zero
    send_item(kmma_pkg::OP_RECORD, 9'd3, 11'sd5);
    send_item(kmma_pkg::OP_RECORD, 9'd3, 11'sd6);
    send_item(kmma_pkg::OP_READ, 9'd3, 11'sd0);
    send_item(kmma_pkg::OP_RECORD, 9'd4, -11'sd5);
    send_item(kmma_pkg::OP_RECORD, 9'd4, -11'sd6);
    send_item(kmma_pkg::OP_READ, 9'd4, 11'sd0);
    send_item(kmma_pkg::OP_CLEAR, 9'd0, 11'sd0);
    send_item(kmma_pkg::OP_READ, 9'd0, 11'sd0);
    send_item(kmma_pkg::OP_RECORD, 9'd0, -11'sd7);
    send_item(kmma_pkg::OP_READ, 9'd0, 11'sd0);
    send_item(kmma_pkg::OP_CLEAR, 9'd511, 11'sd0);
    send_item(kmma_pkg::OP_READ, 9'd511, 11'sd0);

    while (sent < ITEMS) begin
      if ($urandom_range(0, 3) != 0) begin
        if ($urandom_range(0, 4) == 0) key = kmma_pkg::IDX_W'($urandom_range(0, 511));
        else key = hot_keys[3'($urandom_range(0, 7))];
        if ($urandom_range(0, 7) == 0) send_item(kmma_pkg::OP_CLEAR, key, sample_reading());
        n = $urandom_range(1, 6);
        repeat (n) send_item(kmma_pkg::OP_RECORD, key, sample_reading());
        send_item(kmma_pkg::OP_READ, key, sample_reading());
      end else begin
        case ($urandom_range(0, 3))
          0: op = kmma_pkg::OP_RECORD;
          1: op = kmma_pkg::OP_READ;
          2: op = kmma_pkg::OP_CLEAR;
          default: op = OP_NOP;
        endcase
        send_item(op, kmma_pkg::IDX_W'($urandom_range(0, 511)), sample_reading());
      end
    end
    in_valid <= 1'b0;

    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
